/* hw/rtl/led_pattern_and_breathing_driver_macros.svh */
// Assertion macros shared by the LED pattern and breathing driver checkers.
// Needs nothing else; included by the checker file.
`ifndef LED_PATTERN_AND_BREATHING_DRIVER_MACROS_SVH
`define LED_PATTERN_AND_BREATHING_DRIVER_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define LPB_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lpb assertion failed");

// Clocked assertion that also holds during reset.
`define LPB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lpb assertion failed");

`endif

/* hw/rtl/lpb_pkg.sv */
// Shared types, codes and interval tables of the LED pattern and breathing driver.
// Has no dependencies; imported by every module of the block.
`default_nettype none

package lpb_pkg;

  // Mode codes carried by each input transaction.
  localparam logic [2:0] ModeOff    = 3'd0;
  localparam logic [2:0] ModeOn     = 3'd1;
  localparam logic [2:0] ModeSos    = 3'd2;
  localparam logic [2:0] ModeHeart  = 3'd3;
  localparam logic [2:0] ModeBreath = 3'd4;

  // Value of register address bit 2 that selects the led_active_low register.
  localparam logic RegActiveLow = 1'b0;

  localparam int unsigned SlotCount = 32;
  localparam logic [5:0]  SosSteps       = 6'd18;
  localparam logic [5:0]  HeartbeatSteps = 6'd4;

  localparam logic [9:0]  DutyTop   = 10'd990;
  localparam logic [9:0]  DutyStep  = 10'd10;
  localparam logic [31:0] FadePeriodMs = 32'd5;

  localparam logic [9:0] SosTable [SlotCount] = '{
    10'd150, 10'd150, 10'd150, 10'd150, 10'd150, 10'd500,
    10'd500, 10'd150, 10'd500, 10'd150, 10'd500, 10'd500,
    10'd150, 10'd150, 10'd150, 10'd150, 10'd150, 10'd800,
    10'd150, 10'd150, 10'd150, 10'd150, 10'd150, 10'd500,
    10'd500, 10'd150, 10'd500, 10'd150, 10'd500, 10'd500,
    10'd150, 10'd150
  };

  localparam logic [9:0] HeartTable [SlotCount] = '{
    10'd100, 10'd200, 10'd100, 10'd800, 10'd100, 10'd200, 10'd100, 10'd800,
    10'd100, 10'd200, 10'd100, 10'd800, 10'd100, 10'd200, 10'd100, 10'd800,
    10'd100, 10'd200, 10'd100, 10'd800, 10'd100, 10'd200, 10'd100, 10'd800,
    10'd100, 10'd200, 10'd100, 10'd800, 10'd100, 10'd200, 10'd100, 10'd800
  };

  // One control loop pass as it moves from the input stage to the engines.
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
  } lpb_item_t;

  function automatic logic [9:0] lpb_interval(input logic heart, input logic [4:0] idx);
    logic [9:0] val;
    if (heart) begin
      val = HeartTable[idx];
    end else begin
      val = SosTable[idx];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lpb_pattern.sv */
// Blink pattern engine: step index, interval mark, last pattern code and lit flag.
// Depends on lpb_pkg for mode codes, step counts and the interval tables.
`default_nettype none

module lpb_pattern (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic step_i,
  input  wire lpb_pkg::lpb_item_t item_i,
  output logic               lit_o
);
  import lpb_pkg::*;

  logic [4:0]  idx_q, idx_d;
  logic [2:0]  seen_q, seen_d;
  logic [31:0] mark_q, mark_d;
  logic        lit_q, lit_d;

  logic        heart;
  logic [5:0]  len;
  logic [4:0]  idx_eff;
  logic [5:0]  idx_inc;
  logic [9:0]  interval;
  logic [31:0] elapsed;
  logic        due;

  assign heart    = (item_i.mode == ModeHeart);
  assign len      = heart ? HeartbeatSteps : SosSteps;
  assign idx_eff  = ({1'b0, idx_q} >= len) ? 5'd0 : idx_q;
  assign idx_inc  = {1'b0, idx_eff} + 6'd1;
  assign interval = lpb_interval(heart, idx_eff);
  assign elapsed  = item_i.now_ms - mark_q;
  assign due      = (elapsed >= {22'd0, interval});

  always_comb begin
    idx_d  = idx_q;
    seen_d = seen_q;
    mark_d = mark_q;
    lit_d  = lit_q;
    case (item_i.mode)
      ModeOff: begin
        lit_d = 1'b0;
      end
      ModeOn: begin
        lit_d = 1'b1;
      end
      ModeSos, ModeHeart: begin
        if (item_i.mode != seen_q) begin
          // A new pattern starts dark and waits a full first interval.
          idx_d  = 5'd0;
          mark_d = item_i.now_ms;
          seen_d = item_i.mode;
          lit_d  = 1'b0;
        end else begin
          idx_d = idx_eff;
          if (due) begin
            mark_d = item_i.now_ms;
            lit_d  = ~idx_eff[0];
            idx_d  = (idx_inc >= len) ? 5'd0 : idx_inc[4:0];
          end
        end
      end
      ModeBreath: begin
        lit_d = lit_q;
      end
      default: begin
        // Reserved codes: code zero pattern, no table, LED dark on entry then kept.
        if (seen_q != ModeOff) begin
          idx_d  = 5'd0;
          mark_d = item_i.now_ms;
          seen_d = ModeOff;
          lit_d  = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 5'd0;
      seen_q <= ModeOff;
      mark_q <= 32'd0;
      lit_q  <= 1'b1;
    end else if (step_i) begin
      idx_q  <= idx_d;
      seen_q <= seen_d;
      mark_q <= mark_d;
      lit_q  <= lit_d;
    end
  end

  assign lit_o = lit_d;

endmodule

`default_nettype wire

/* hw/rtl/lpb_fade.sv */
// Breathing ramp: duty value, ramp direction and the 5 ms step mark.
// Depends on lpb_pkg for the duty limits and the mode codes.
`default_nettype none

module lpb_fade (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic step_i,
  input  wire lpb_pkg::lpb_item_t item_i,
  output logic [9:0]         duty_o
);
  import lpb_pkg::*;

  logic [9:0]  duty_q, duty_d;
  logic        rising_q, rising_d;
  logic [31:0] mark_q, mark_d;
  logic [9:0]  duty_up;
  logic        due;

  assign duty_up = duty_q + DutyStep;
  assign due     = ((item_i.now_ms - mark_q) >= FadePeriodMs);

  always_comb begin
    duty_d   = duty_q;
    rising_d = rising_q;
    mark_d   = mark_q;
    if ((item_i.mode == ModeBreath) && due) begin
      mark_d = item_i.now_ms;
      if (rising_q) begin
        if (duty_up >= DutyTop) begin
          duty_d   = DutyTop;
          rising_d = 1'b0;
        end else begin
          duty_d = duty_up;
        end
      end else begin
        if (duty_q <= DutyStep) begin
          duty_d   = 10'd0;
          rising_d = 1'b1;
        end else begin
          duty_d = duty_q - DutyStep;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q   <= 10'd0;
      rising_q <= 1'b1;
      mark_q   <= 32'd0;
    end else if (step_i) begin
      duty_q   <= duty_d;
      rising_q <= rising_d;
      mark_q   <= mark_d;
    end
  end

  assign duty_o = duty_d;

endmodule

`default_nettype wire

/* hw/rtl/led_pattern_and_breathing_driver.sv */
// Top level of the LED pattern and breathing driver: stream stages and APB register.
// Depends on lpb_pkg, lpb_pattern and lpb_fade.
//
// Channel   Direction  Payload (low bit first)                          Handshake
// s_axis    in         now_ms[31:0], mode[34:32], zero pad to 40 bits   tvalid/tready
// m_axis    out        led_lit, led_pin_level, pwm_enable,               tvalid/tready
//                      pwm_compare[12:3], zero pad to 16 bits
// apb       in         led_active_low at byte address 0                  psel/penable
//
// Every transaction waits in the input register; then the pattern and fade engines
// update their state and the result register loads in the same edge. One transaction
// is accepted per cycle while the output is not stalled.
// Reset clears both stages, sets led_active_low and starts with the LED logically lit.
// When the output is stalled the input register still takes one more transaction, and
// after that s_axis_tready follows m_axis_tready combinationally.
`default_nettype none

module led_pattern_and_breathing_driver (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  // Input stream.
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [39:0] s_axis_tdata,   // now_ms[31:0], mode[34:32], zero pad
  // Result stream.
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // led_lit, led_pin_level, pwm_enable,
                                            // pwm_compare[12:3], zero pad
  // Register port.
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic [2:0]  paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import lpb_pkg::*;

  // Input stage.
  logic      in_valid_q, in_valid_d;
  lpb_item_t in_item_q;

  // Result stage.
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_data_q;

  logic       active_low_q;
  logic       s_hs;
  logic       advance;
  logic       lit_next;
  logic [9:0] duty_next;
  logic       pin_level;
  logic       pwm_en;

  // The input item moves into the result stage whenever that stage is empty or drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_hs) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      in_item_q.now_ms <= s_axis_tdata[31:0];
      in_item_q.mode   <= s_axis_tdata[34:32];
    end
  end

  // The engines commit their state exactly when the item enters the result stage.
  lpb_pattern u_pattern (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .lit_o  (lit_next)
  );

  lpb_fade u_fade (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .duty_o (duty_next)
  );

  assign pin_level = lit_next ^ active_low_q;
  assign pwm_en    = (in_item_q.mode == ModeBreath);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {3'd0, duty_next, pwm_en, pin_level, lit_next};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Configuration register; user writes only with no transaction in flight; unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == RegActiveLow)) begin
      active_low_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegActiveLow) ? {31'd0, active_low_q} : 32'd0;

endmodule

`default_nettype wire

/* hw/rtl/lpb_checker.sv */
// Port-level checker for the LED pattern and breathing driver, bound to the top level.
// Depends on the macro header led_pattern_and_breathing_driver_macros.svh.
`default_nettype none

`include "led_pattern_and_breathing_driver_macros.svh"

module lpb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic        pready
);

  logic       al_q;
  logic [9:0] prev_cmp_q;
  logic [9:0] cmp;
  logic [9:0] cmp_diff;
  logic       out_stall;
  logic       pin_ok;

  assign cmp      = m_axis_tdata[12:3];
  assign cmp_diff = (cmp >= prev_cmp_q) ? (cmp - prev_cmp_q) : (prev_cmp_q - cmp);

  // A result that is offered but not taken must be held.
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign pin_ok    = (m_axis_tdata[1] == (m_axis_tdata[0] ^ al_q));

  // Shadow of the active-low register from the write port, and last accepted compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      al_q       <= 1'b1;
      prev_cmp_q <= 10'd0;
    end else begin
      if (psel && penable && pwrite && pready && !paddr[2]) begin
        al_q <= pwdata[0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        prev_cmp_q <= cmp;
      end
    end
  end

  `LPB_ASSERT_RST(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))
  `LPB_ASSERT_RST(a_cmp_range, clk_i, rst_ni, m_axis_tvalid |-> cmp <= 10'd990)
  `LPB_ASSERT_RST(a_cmp_step, clk_i, rst_ni, m_axis_tvalid |-> cmp_diff <= 10'd10)
  `LPB_ASSERT_RST(a_pin_polarity, clk_i, rst_ni, m_axis_tvalid |-> pin_ok)
  `LPB_ASSERT_ALWAYS(a_pready_high, clk_i, pready)

endmodule

bind led_pattern_and_breathing_driver lpb_checker u_lpb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .pready        (pready)
);

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for led_pattern_and_breathing_driver.
// Needs only the block's RTL and lpb_pkg. A built-in model of the blink tables, the
// breathing ramp and the pin polarity predicts every result under random flow control.
`timescale 1ns / 1ps

module tb;
  import lpb_pkg::*;

  // The three spare mode codes all act as the "no pattern" code for the blink engine.
  localparam logic [2:0]  ModeSpareA    = 3'd5;
  localparam logic [2:0]  ModeSpareB    = 3'd6;
  localparam logic [2:0]  ModeSpareC    = 3'd7;
  localparam logic [2:0]  NoPattern     = 3'd0;
  localparam logic [2:0]  ActiveLowAddr = 3'd0;

  localparam int unsigned SosLen     = 18;
  localparam int unsigned HeartLen   = 4;
  localparam logic [10:0] DutyMax    = 11'd990;
  localparam logic [10:0] DutyInc    = 11'd10;
  localparam logic [31:0] FadeMs     = 32'd5;

  // Extra pause that settle() adds once every pending result has drained.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned StallCycles  = 60;
  localparam int unsigned CycleLimit   = 600000;

  // One expected result transaction, with the fields in the order of m_axis_tdata.
  typedef struct packed {
    logic       lit;
    logic       pin;
    logic       pwm_on;
    logic [9:0] duty;
  } led_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // now_ms[31:0], mode[34:32], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // led_lit, led_pin_level, pwm_enable,
                                     // pwm_compare[12:3], zero pad
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  led_pattern_and_breathing_driver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Private copy of the blink interval tables. The SOS table is only ever indexed below
  // its length of 18, and the heartbeat table below 4.
  int unsigned sos_gap_ms [SosLen] = '{
    150, 150, 150, 150, 150, 500, 500, 150, 500,
    150, 500, 500, 150, 150, 150, 150, 150, 800
  };
  int unsigned heart_gap_ms [HeartLen] = '{100, 200, 100, 800};

  // Predicted state of the block, updated once per accepted input transaction.
  logic [4:0]  blink_step;
  logic [2:0]  blink_code;
  logic [31:0] blink_mark;
  logic [31:0] fade_mark;
  logic [9:0]  fade_duty;
  logic        fade_up;
  logic        lit_now;
  logic        active_low_now;

  led_result_t pending_leds[$];   // results accepted at the input but not yet seen

  int unsigned error_count     = 0;
  int unsigned passes_sent     = 0;
  int unsigned results_seen    = 0;
  int unsigned polarity_writes = 0;
  int unsigned cycle_count     = 0;
  int unsigned sink_gap        = 0;
  logic        gaps_on         = 1'b1;
  logic        sink_stalled    = 1'b0;
  logic [31:0] clock_ms;
  event        stall_kick;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             results_seen);
    error_count++;
  endtask

  function automatic void reset_led_model();
    blink_step     = '0;
    blink_code     = NoPattern;
    blink_mark     = '0;
    fade_mark      = '0;
    fade_duty      = '0;
    fade_up        = 1'b1;
    lit_now        = 1'b1;
    active_low_now = 1'b1;
  endfunction

  // Blink engine. A change of pattern code restarts the table and darkens the LED;
  // on that pass the freshly set mark keeps the interval from being met.
  function automatic void step_blink(input logic [2:0] code, input logic [31:0] now);
    int unsigned len;
    logic [31:0] gap;
    if (code != blink_code) begin
      blink_step = '0;
      blink_mark = now;
      blink_code = code;
      lit_now    = 1'b0;
    end
    if (code == ModeSos) begin
      len = SosLen;
    end else if (code == ModeHeart) begin
      len = HeartLen;
    end else begin
      return;
    end
    if (blink_step >= len) begin
      blink_step = '0;
    end
    gap = (code == ModeSos) ? sos_gap_ms[blink_step] : heart_gap_ms[blink_step];
    // The subtraction wraps at 32 bits, so a tick counter roll-over is harmless.
    if (now - blink_mark >= gap) begin
      blink_mark = now;
      lit_now    = ~blink_step[0];
      blink_step = blink_step + 5'd1;
      if (blink_step >= len) begin
        blink_step = '0;
      end
    end
  endfunction

  // Breathing ramp: one step of 10 every 5 ms, turning around at 0 and 990.
  function automatic void step_fade(input logic [31:0] now);
    logic [10:0] up;
    if (now - fade_mark < FadeMs) begin
      return;
    end
    fade_mark = now;
    if (fade_up) begin
      up = fade_duty + DutyInc;
      if (up >= DutyMax) begin
        up      = DutyMax;
        fade_up = 1'b0;
      end
      fade_duty = up[9:0];
    end else if (fade_duty <= DutyInc) begin
      fade_duty = '0;
      fade_up   = 1'b1;
    end else begin
      fade_duty = fade_duty - DutyInc[9:0];
    end
  endfunction

  function automatic led_result_t predict_led(input logic [31:0] now, input logic [2:0] mode);
    led_result_t r;
    case (mode)
      ModeOff:            lit_now = 1'b0;
      ModeOn:             lit_now = 1'b1;
      ModeSos, ModeHeart: step_blink(mode, now);
      ModeBreath:         step_fade(now);
      default:            step_blink(NoPattern, now);
    endcase
    r.lit    = lit_now;
    r.pin    = active_low_now ? ~lit_now : lit_now;
    r.pwm_on = (mode == ModeBreath);
    r.duty   = fade_duty;
    return r;
  endfunction

  // Offers one control loop pass and returns at the edge where it is accepted. tvalid
  // is only lowered when a gap is drawn, so back-to-back passes keep it high.
  task automatic send_pass(input logic [31:0] now, input logic [2:0] mode);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, mode, now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_leds.push_back(predict_led(now, mode));
    passes_sent++;
  endtask

  // Lets every outstanding result drain so that the register may be written safely.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One APB transfer to the polarity register; a read is checked against the model.
  task automatic apb_transfer(input logic is_write, input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ActiveLowAddr;
    pwdata  <= {31'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (!is_write && prdata[0] !== active_low_now) begin
      report_mismatch("prdata led_active_low", prdata[0], active_low_now);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_polarity(input logic value);
    apb_transfer(1'b1, value);
    active_low_now = value;
    apb_transfer(1'b0, value);
    polarity_writes++;
  endtask

  // A run of passes in one blink mode, with time stepping mostly around the table
  // intervals. Every so often a stray mode breaks the run and may restart the pattern.
  task automatic blink_run(input logic [2:0] code, input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        clock_ms += $urandom_range(0, 60);
      end else begin
        clock_ms += $urandom_range(90, 820);
      end
      if ($urandom_range(0, 19) == 0) begin
        send_pass(clock_ms, 3'($urandom_range(0, 7)));
      end else begin
        send_pass(clock_ms, code);
      end
    end
  endtask

  task automatic breath_run(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      clock_ms += $urandom_range(0, 9);
      send_pass(clock_ms, ModeBreath);
    end
  endtask

  task automatic test_directed();
    // Reset state: a spare code matches the reset pattern code, so the LED stays lit.
    send_pass(32'd0, ModeSpareB);
    send_pass(32'd0, ModeBreath);            // less than 5 ms since the fade mark
    send_pass(32'd5, ModeBreath);            // first ramp step
    send_pass(32'd9, ModeBreath);
    send_pass(32'd1000, ModeSos);            // pattern change darkens the LED
    send_pass(32'd1149, ModeSos);            // one ms short of the interval
    send_pass(32'd1150, ModeSos);            // exactly the interval: lit
    send_pass(32'd1200, ModeOff);            // leaves the remembered pattern alone
    send_pass(32'd1300, ModeSos);            // odd step darkens
    send_pass(32'd1301, ModeOn);
    send_pass(32'd2000, ModeHeart);
    send_pass(32'd2100, ModeHeart);
    send_pass(32'd2150, ModeBreath);
    send_pass(32'd2300, ModeHeart);
    send_pass(32'd2301, ModeSpareA);         // spare code counts as a pattern change
    send_pass(32'd2302, ModeSpareC);         // another spare code, same no-pattern code: nothing changes
    send_pass(32'd2303, ModeOn);
    send_pass(32'd2304, ModeSpareB);
    send_pass(32'hFFFF_FF00, ModeSos);
    send_pass(32'h0000_0050, ModeSos);       // interval measured across the roll-over
    send_pass(32'hFFFF_FFFF, ModeBreath);
    send_pass(32'h0000_0003, ModeBreath);
    send_pass(32'h7FFF_FFFF, ModeOff);
    send_pass(32'hAAAA_AAAA, ModeHeart);
    send_pass(32'h5555_5555, ModeHeart);
  endtask

  task automatic test_polarity();
    int unsigned k;
    settle();
    set_polarity(1'b0);
    for (k = 0; k < 12; k++) begin
      send_pass($urandom, 3'($urandom_range(0, 7)));
    end
    settle();
    set_polarity(1'b1);
    for (k = 0; k < 12; k++) begin
      send_pass($urandom, 3'($urandom_range(0, 7)));
    end
  endtask

  // Long runs walk through the whole SOS table several times and wrap the heartbeat.
  task automatic test_blink_tables();
    clock_ms = $urandom;
    blink_run(ModeSos, 120);
    blink_run(ModeHeart, 60);
    clock_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
    blink_run(ModeSos, 80);
    blink_run(ModeHeart, 40);
  endtask

  // About 150 passes take the duty from 0 to the top; 600 cover a full rise and fall.
  task automatic test_breathing_ramp();
    gaps_on = 1'b0;
    breath_run(300);
    gaps_on = 1'b1;
    clock_ms = 32'hFFFF_FE00;
    breath_run(300);
  endtask

  // The sink holds off for a long stretch while passes keep coming, so both register
  // stages fill and the input stalls.
  task automatic test_backpressure();
    int unsigned k;
    gaps_on = 1'b0;
    -> stall_kick;
    for (k = 0; k < 24; k++) begin
      clock_ms += $urandom_range(0, 300);
      send_pass(clock_ms, 3'($urandom_range(0, 7)));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_mix(input int unsigned passes);
    int unsigned sent;
    int unsigned pick;
    int unsigned count;
    int unsigned k;
    sent = 0;
    while (sent < passes) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick  = $urandom_range(0, 9);
      count = $urandom_range(4, 40);
      if (pick < 4) begin
        blink_run(ModeSos, count);
      end else if (pick < 6) begin
        blink_run(ModeHeart, count);
      end else if (pick < 8) begin
        breath_run(count);
      end else begin
        for (k = 0; k < count; k++) begin
          send_pass($urandom, 3'($urandom_range(0, 7)));
        end
      end
      sent += count;
      if ($urandom_range(0, 7) == 0) begin
        clock_ms = $urandom;
      end
      if ($urandom_range(0, 11) == 0) begin
        settle();
        set_polarity(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result side: checks each result transaction against the oldest prediction and
  // draws a fresh idle count after each one.
  always @(posedge clk_i) begin
    led_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_leds.size() == 0) begin
          report_mismatch("unexpected result, m_axis_tdata", m_axis_tdata, 0);
        end else begin
          want = pending_leds.pop_front();
          if (m_axis_tdata[0] !== want.lit) begin
            report_mismatch("led_lit", m_axis_tdata[0], want.lit);
          end
          if (m_axis_tdata[1] !== want.pin) begin
            report_mismatch("led_pin_level", m_axis_tdata[1], want.pin);
          end
          if (m_axis_tdata[2] !== want.pwm_on) begin
            report_mismatch("pwm_enable", m_axis_tdata[2], want.pwm_on);
          end
          if (m_axis_tdata[12:3] !== want.duty) begin
            report_mismatch("pwm_compare", m_axis_tdata[12:3], want.duty);
          end
        end
        results_seen++;
        sink_gap = gaps_on ? $urandom_range(0, 9) : 0;
      end else if (sink_gap > 0) begin
        sink_gap--;
      end
      m_axis_tready <= (sink_gap == 0) && !sink_stalled;
    end
  end

  // The long stall of the result side is timed here, apart from the per-item idling.
  initial begin
    forever begin
      @(stall_kick);
      sink_stalled <= 1'b1;
      repeat (StallCycles) @(posedge clk_i);
      sink_stalled <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count,
               pending_leds.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    reset_led_model();
    clock_ms = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_transfer(1'b0, 1'b0);   // the polarity register must read back its reset value
    test_directed();
    test_polarity();
    test_blink_tables();
    test_breathing_ramp();
    test_backpressure();
    test_random_mix(1000);
    settle();

    $display("Ran %0d control passes and checked %0d results across %0d polarity writes,",
             passes_sent, results_seen, polarity_writes);
    $display("covering both blink tables, full breathing ramps, mode changes and a long stall.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
